[design/ssst_pkg.sv]
package ssst_pkg;

  localparam int IdW      = 32;
  localparam int FactorW  = 11;
  localparam int StampW   = 32;
  localparam int ScoreW   = 24;
  localparam int RomAw    = 10;
  localparam int RomDepth = 1024;
  localparam int CfgIdxW  = 2;

  localparam logic [ScoreW-1:0] ScoreMax       = '1;
  localparam logic [ScoreW-1:0] ThresholdReset = 24'd360881;
  localparam logic [ScoreW-1:0] DecayReset     = 24'd65536;

  localparam logic [63:0] RomStart = 64'd140737488355;
  localparam logic [63:0] RomRatio = 64'd10790018124;

  typedef enum logic [CfgIdxW-1:0] {
    REG_THRESHOLD = 2'd0,
    REG_DECAY     = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECAY
  } state_t;

  typedef logic [ScoreW-1:0] rom_t [RomDepth];

  // Penalty 0.0005*exp(10*(1 - f/1024)) in Q8.16, built by repeated growth.
  function automatic rom_t build_rom();
    rom_t        tbl;
    logic [63:0] v;
    logic [63:0] hi;
    logic [63:0] lo;
    logic [63:0] r;
    v = RomStart;
    for (int f = RomDepth - 1; f >= 0; f--) begin
      hi = v >> 24;
      lo = v & 64'hFFFFFF;
      v = v + ((hi * RomRatio) >> 16) + ((lo * RomRatio) >> 40);
      r = v + 64'h80000000;
      tbl[f] = r[32 +: ScoreW];
    end
    return tbl;
  endfunction

endpackage

[design/ssst_penalty_rom.sv]
module ssst_penalty_rom
  import ssst_pkg::*;
(
  input  logic              clk,
  input  logic              en,
  input  logic [RomAw-1:0]  addr,
  output logic [ScoreW-1:0] data
);

  localparam rom_t PenaltyTable = build_rom();

  always_ff @(posedge clk) begin
    if (en) begin
      data <= PenaltyTable[addr];
    end
  end

endmodule

[design/ssst_cell.sv]
module ssst_cell
  import ssst_pkg::*;
#(
  parameter int DEPTH = 16,
  parameter int IDX   = 0
) (
  input  logic clk,
  input  logic rst,
  input  logic [IdW-1:0] key,
  input  logic [$clog2(DEPTH)+ScoreW+StampW+2*$clog2(DEPTH)+3-1:0] token_in,
  output logic [$clog2(DEPTH)+ScoreW+StampW+2*$clog2(DEPTH)+3-1:0] token_out,
  input  logic [$clog2(DEPTH)+IdW+ScoreW+StampW+3-1:0] wr_in
);

  localparam int IdxW = $clog2(DEPTH);
  localparam logic [IdxW-1:0] MyIdx = IdxW'(IDX);

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IdxW-1:0]   hit_idx;
    logic [ScoreW-1:0] hit_score;
    logic              free;
    logic [IdxW-1:0]   free_idx;
    logic [IdxW-1:0]   old_idx;
    logic [StampW-1:0] old_stamp;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [IdW-1:0]    sender;
    logic [ScoreW-1:0] score;
    logic              stamp_en;
    logic [StampW-1:0] stamp;
    logic              keep;
  } wr_t;

  token_t tin;
  token_t token_next;
  token_t token;
  wr_t    wr;

  logic [IdW-1:0]    sender;
  logic [ScoreW-1:0] score;
  logic [StampW-1:0] stamp;
  logic              valid;

  assign tin       = token_t'(token_in);
  assign wr        = wr_t'(wr_in);
  assign token_out = token;

  always_comb begin
    token_next = tin;
    if (valid && !tin.hit && sender == key) begin
      token_next.hit       = 1'b1;
      token_next.hit_idx   = MyIdx;
      token_next.hit_score = score;
    end
    if (!valid && !tin.free) begin
      token_next.free     = 1'b1;
      token_next.free_idx = MyIdx;
    end
    if (valid && stamp < tin.old_stamp) begin
      token_next.old_idx   = MyIdx;
      token_next.old_stamp = stamp;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      token.valid <= 1'b0;
    end else begin
      token.valid <= tin.valid;
    end
    token.hit       <= token_next.hit;
    token.hit_idx   <= token_next.hit_idx;
    token.hit_score <= token_next.hit_score;
    token.free      <= token_next.free;
    token.free_idx  <= token_next.free_idx;
    token.old_idx   <= token_next.old_idx;
    token.old_stamp <= token_next.old_stamp;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr.en && wr.idx == MyIdx) begin
      valid <= wr.keep;
    end
  end

  always_ff @(posedge clk) begin
    if (wr.en && wr.idx == MyIdx) begin
      sender <= wr.sender;
      score  <= wr.score;
      if (wr.stamp_en) begin
        stamp <= wr.stamp;
      end
    end
  end

endmodule

[design/sender_suspicion_score_table_unit.sv]
// Channel   Handshake                Word
// input     in_valid / in_stall      sender_id, check_factor, now_time
// output    out_valid / out_stall    report, still_tracked, evicted
// config    wr_en, wr_index          wr_data
//
// The search token walks the chain of table cells, one register per cell; the scan
// result is then collected into registers, and the score is decayed and written back
// as the result word is registered. The next input word is taken only once the unit
// is idle again, so a new item is not accepted before the last one is finished.
// Reset clears all entry valid bits and loads the register defaults at once.
// The input stalls while an item is in flight; a finished word waits in the
// output register, and write-back holds while that register is still full.
module sender_suspicion_score_table_unit
  import ssst_pkg::*;
#(
  parameter int TABLE_DEPTH = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [IdW-1:0]     sender_id,
  input  logic [FactorW-1:0] check_factor,
  input  logic [StampW-1:0]  now_time,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               report,
  output logic               still_tracked,
  output logic               evicted,
  input  logic               wr_en,
  input  logic [CfgIdxW-1:0] wr_index,
  input  logic [ScoreW-1:0]  wr_data
);

  localparam int IdxW = $clog2(TABLE_DEPTH);

  typedef struct packed {
    logic              valid;
    logic              hit;
    logic [IdxW-1:0]   hit_idx;
    logic [ScoreW-1:0] hit_score;
    logic              free;
    logic [IdxW-1:0]   free_idx;
    logic [IdxW-1:0]   old_idx;
    logic [StampW-1:0] old_stamp;
  } token_t;

  typedef struct packed {
    logic              en;
    logic [IdxW-1:0]   idx;
    logic [IdW-1:0]    sender;
    logic [ScoreW-1:0] score;
    logic              stamp_en;
    logic [StampW-1:0] stamp;
    logic              keep;
  } wr_t;

  state_t state;
  state_t state_next;

  logic               in_accept;
  logic               start;
  logic [IdW-1:0]     key;
  logic               suspect;
  logic [StampW-1:0]  stamp_in;
  logic [ScoreW-1:0]  penalty;
  logic [ScoreW-1:0]  threshold;
  logic [ScoreW-1:0]  decay;

  token_t chain [TABLE_DEPTH+1];
  token_t result;
  wr_t    wr;

  logic               act;
  logic [IdxW-1:0]    slot;
  logic               evict_flag;
  logic [ScoreW-1:0]  score1;
  logic               stamp_en;

  logic [ScoreW-1:0]  base;
  logic [ScoreW:0]    sum;
  logic [ScoreW-1:0]  score1_next;
  logic [ScoreW-1:0]  score2;
  logic               report_next;
  logic               fire;

  assign in_accept = in_valid && !in_stall;

  ssst_penalty_rom u_rom (
    .clk  (clk),
    .en   (in_accept),
    .addr (check_factor[RomAw-1:0]),
    .data (penalty)
  );

  always_comb begin
    chain[0]           = '0;
    chain[0].valid     = start;
    chain[0].old_stamp = '1;
  end

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    ssst_cell #(
      .DEPTH (TABLE_DEPTH),
      .IDX   (i)
    ) u_cell (
      .clk       (clk),
      .rst       (rst),
      .key       (key),
      .token_in  (chain[i]),
      .token_out (chain[i+1]),
      .wr_in     (wr)
    );
  end

  assign result = chain[TABLE_DEPTH];

  always_comb begin
    base = result.hit ? result.hit_score : '0;
    sum  = {1'b0, base} + {1'b0, (suspect ? penalty : {ScoreW{1'b0}})};
    score1_next = sum[ScoreW] ? ScoreMax : sum[ScoreW-1:0];
  end

  always_comb begin
    report_next = act && score1 != '0 && score1 > threshold;
    score2      = score1 > decay ? score1 - decay : '0;
    fire        = state == ST_DECAY && !(out_valid && out_stall);
    wr.en       = fire && act;
    wr.idx      = slot;
    wr.sender   = key;
    wr.score    = score2;
    wr.stamp_en = stamp_en;
    wr.stamp    = stamp_in;
    wr.keep     = score2 != '0;
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (result.valid) begin
          state_next = ST_DECAY;
        end
      end
      ST_DECAY: begin
        if (fire) begin
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      start <= 1'b0;
    end else begin
      state <= state_next;
      start <= in_accept;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      key      <= sender_id;
      suspect  <= !check_factor[FactorW-1];
      stamp_in <= now_time;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_SCAN && result.valid) begin
      act        <= result.hit || suspect;
      evict_flag <= !result.hit && suspect && !result.free;
      stamp_en   <= suspect;
      score1     <= score1_next;
      if (result.hit) begin
        slot <= result.hit_idx;
      end else if (result.free) begin
        slot <= result.free_idx;
      end else begin
        slot <= result.old_idx;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      report        <= report_next;
      still_tracked <= act && score2 != '0;
      evicted       <= evict_flag;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ThresholdReset;
      decay     <= DecayReset;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_THRESHOLD: threshold <= wr_data;
        REG_DECAY:     decay     <= wr_data;
        default: begin
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_token_only_in_scan: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> state == ST_SCAN)
    else $error("search token left the chain outside a scan");

  a_accept_launches: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> start && state == ST_SCAN)
    else $error("accepted word did not launch a search");

  a_write_in_decay: assert property (@(posedge clk) disable iff (rst)
    wr.en |-> state == ST_DECAY && !(out_valid && out_stall))
    else $error("table written outside write-back");

  a_result_from_decay: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == ST_DECAY)
    else $error("result word appeared without write-back");

  a_evict_new_entry: assert property (@(posedge clk) disable iff (rst)
    fire && evict_flag |-> act && stamp_en)
    else $error("eviction without a suspect new sender");
`endif

endmodule
